// ----- rtl/kmn_pkg.sv -----
`default_nettype none
package kmn_pkg;

	localparam int AdcW      = 10;
	localparam int KeyW      = 3;
	localparam int FuncW     = 2;
	localparam int SubW      = 4;
	localparam int IdxW      = 6;
	localparam int CntW      = 4;
	localparam int NumCfg    = 4;
	localparam int CfgIdxW   = 2;
	localparam int NumSlots  = 4;

	localparam int NUM_FUNCTIONS_DEF = 4;
	localparam int SUB_STRIDE_DEF    = 12;

	localparam logic [CntW-1:0] CountReset = CntW'(12);

	// Ladder thresholds
	localparam logic [AdcW-1:0] ThrNoneHi = AdcW'(1000);
	localparam logic [AdcW-1:0] ThrRight  = AdcW'(50);
	localparam logic [AdcW-1:0] ThrUp     = AdcW'(250);
	localparam logic [AdcW-1:0] ThrDown   = AdcW'(450);
	localparam logic [AdcW-1:0] ThrLeft   = AdcW'(650);
	localparam logic [AdcW-1:0] ThrSelect = AdcW'(850);

	typedef enum logic [KeyW-1:0] {
		KEY_NONE   = 3'd0,
		KEY_RIGHT  = 3'd1,
		KEY_UP     = 3'd2,
		KEY_DOWN   = 3'd3,
		KEY_LEFT   = 3'd4,
		KEY_SELECT = 3'd5
	} key_t;

endpackage
`default_nettype wire

// ----- rtl/kmn_in_if.sv -----
`default_nettype none
interface kmn_in_if;
	logic                       valid;
	logic                       ready;
	logic [kmn_pkg::AdcW-1:0]   adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/kmn_out_if.sv -----
`default_nettype none
interface kmn_out_if;
	logic                        valid;
	logic                        ready;
	logic [kmn_pkg::KeyW-1:0]    key_code;
	logic                        select_pressed;
	logic [kmn_pkg::FuncW-1:0]   active_function;
	logic [kmn_pkg::SubW-1:0]    active_sub;
	logic [kmn_pkg::IdxW-1:0]    menu_state_index;
	logic                        menu_state_valid;

	modport source (output valid, output key_code, output select_pressed,
		output active_function, output active_sub, output menu_state_index,
		output menu_state_valid, input ready);
	modport sink (input valid, input key_code, input select_pressed,
		input active_function, input active_sub, input menu_state_index,
		input menu_state_valid, output ready);
endinterface
`default_nettype wire

// ----- rtl/kmn_key_decode.sv -----
`default_nettype none
module kmn_key_decode (
	input  wire logic [kmn_pkg::AdcW-1:0] sample,
	output kmn_pkg::key_t                 key
);

	always_comb begin
		if (sample > kmn_pkg::ThrNoneHi) begin
			key = kmn_pkg::KEY_NONE;
		end else if (sample < kmn_pkg::ThrRight) begin
			key = kmn_pkg::KEY_RIGHT;
		end else if (sample < kmn_pkg::ThrUp) begin
			key = kmn_pkg::KEY_UP;
		end else if (sample < kmn_pkg::ThrDown) begin
			key = kmn_pkg::KEY_DOWN;
		end else if (sample < kmn_pkg::ThrLeft) begin
			key = kmn_pkg::KEY_LEFT;
		end else if (sample < kmn_pkg::ThrSelect) begin
			key = kmn_pkg::KEY_SELECT;
		end else begin
			key = kmn_pkg::KEY_NONE;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/keypad_menu_navigator_top.sv -----
`default_nettype none
// Channel    Dir  Beat payload
// sample_ch  in   adc_sample[9:0]
// result_ch  out  key_code, select_pressed, active_function, active_sub,
//                 menu_state_index, menu_state_valid
// cfg_*      in   cfg_we, cfg_index[1:0], cfg_data[3:0] (sub counts 0..3)
//
// One beat per cycle sustained while result_ch is ready: every sample beat
// yields exactly one result beat, through the sample register and then the
// result register. The menu state update sits combinationally between those
// two registers.
// Reset clears function, sub-selections, press lock and index; counts go to 12.
// A stalled result holds in the result register while the sample register
// still takes one more beat; ready back-pressures only when both are full.
module keypad_menu_navigator_top #(
	parameter int NUM_FUNCTIONS = kmn_pkg::NUM_FUNCTIONS_DEF,
	parameter int SUB_STRIDE    = kmn_pkg::SUB_STRIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	kmn_in_if.sink                             sample_ch,
	kmn_out_if.source                          result_ch,
	input  wire logic                          cfg_we,
	input  wire logic [kmn_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [kmn_pkg::CntW-1:0]      cfg_data
);

	localparam int FW  = kmn_pkg::FuncW;
	localparam int SW  = kmn_pkg::SubW;
	localparam int CW  = kmn_pkg::CntW;
	localparam int IW  = kmn_pkg::IdxW;
	localparam int NS  = kmn_pkg::NumSlots;

	// Configuration registers
	logic [CW-1:0] sub_count_q [kmn_pkg::NumCfg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kmn_pkg::NumCfg; i++) sub_count_q[i] <= kmn_pkg::CountReset;
		end else if (cfg_we) begin
			sub_count_q[cfg_index] <= cfg_data;
		end
	end

	// Sample register (stage 1)
	logic                     valid_s1;
	logic [kmn_pkg::AdcW-1:0] adc_s1;
	logic                     out_free;
	logic                     fire;

	assign out_free        = !result_ch.valid || result_ch.ready;
	assign fire            = valid_s1 && out_free;
	assign sample_ch.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.ready && sample_ch.valid) begin
			adc_s1 <= sample_ch.adc_sample;
		end
	end

	kmn_pkg::key_t key;

	kmn_key_decode u_decode (
		.sample (adc_s1),
		.key    (key)
	);

	// Menu state
	logic [FW-1:0] cur_fn_q;
	logic [SW-1:0] sub_sel_q [NS];
	logic          lock_q;
	logic [IW-1:0] idx_q;
	logic          idx_valid_q;

	logic [FW-1:0] cur_fn_d;
	logic [SW-1:0] sub_sel_d [NS];
	logic          lock_d;
	logic [IW-1:0] idx_d;
	logic          idx_valid_d;
	logic          sel_d;

	logic [CW:0]   cnt_raw;
	logic [CW:0]   cnt_eff;
	logic [SW-1:0] cur_sub;
	logic [SW:0]   sub_inc;
	logic [FW:0]   fn_inc;
	logic [FW-1:0] fn_up;
	logic [FW-1:0] fn_dn;
	logic [SW-1:0] sub_rt;
	logic [SW-1:0] sub_lt;
	logic          moved;

	always_comb begin
		// Clamp the configured count into 1..SUB_STRIDE
		cnt_raw = {1'b0, sub_count_q[cur_fn_q]};
		if (cnt_raw == '0) begin
			cnt_eff = (CW+1)'(1);
		end else if (cnt_raw > (CW+1)'(SUB_STRIDE)) begin
			cnt_eff = (CW+1)'(SUB_STRIDE);
		end else begin
			cnt_eff = cnt_raw;
		end

		cur_sub = sub_sel_q[cur_fn_q];
		sub_inc = {1'b0, cur_sub} + (SW+1)'(1);
		sub_rt  = (sub_inc >= cnt_eff) ? '0 : sub_inc[SW-1:0];
		sub_lt  = (cur_sub == '0) ? SW'(cnt_eff - (CW+1)'(1)) : cur_sub - SW'(1);

		fn_inc = {1'b0, cur_fn_q} + (FW+1)'(1);
		fn_up  = (fn_inc >= (FW+1)'(NUM_FUNCTIONS)) ? '0 : fn_inc[FW-1:0];
		fn_dn  = (cur_fn_q == '0) ? FW'(NUM_FUNCTIONS - 1) : cur_fn_q - FW'(1);
	end

	always_comb begin
		cur_fn_d    = cur_fn_q;
		sub_sel_d   = sub_sel_q;
		lock_d      = lock_q;
		sel_d       = 1'b0;
		moved       = 1'b0;
		if (key == kmn_pkg::KEY_NONE) begin
			lock_d = 1'b0;
		end else if (!lock_q) begin
			lock_d = 1'b1;
			case (key)
				kmn_pkg::KEY_UP: begin
					cur_fn_d = fn_up;
					moved    = 1'b1;
				end
				kmn_pkg::KEY_DOWN: begin
					cur_fn_d = fn_dn;
					moved    = 1'b1;
				end
				kmn_pkg::KEY_RIGHT: begin
					sub_sel_d[cur_fn_q] = sub_rt;
					moved               = 1'b1;
				end
				kmn_pkg::KEY_LEFT: begin
					sub_sel_d[cur_fn_q] = sub_lt;
					moved               = 1'b1;
				end
				default: begin
					sel_d = 1'b1;
				end
			endcase
		end

		// Index of the landing spot; fits in six bits with the default function count and stride
		if (moved) begin
			idx_d       = IW'((IW+1)'(cur_fn_d) * (IW+1)'(SUB_STRIDE)
				+ (IW+1)'(sub_sel_d[cur_fn_d]));
			idx_valid_d = 1'b1;
		end else begin
			idx_d       = idx_q;
			idx_valid_d = idx_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_fn_q    <= '0;
			for (int i = 0; i < NS; i++) sub_sel_q[i] <= '0;
			lock_q      <= 1'b0;
			idx_q       <= '0;
			idx_valid_q <= 1'b0;
		end else if (fire) begin
			cur_fn_q    <= cur_fn_d;
			sub_sel_q   <= sub_sel_d;
			lock_q      <= lock_d;
			idx_q       <= idx_d;
			idx_valid_q <= idx_valid_d;
		end
	end

	// Result register: load on each processed beat, drop valid once taken
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	assign result_ch.valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			result_ch.key_code         <= key;
			result_ch.select_pressed   <= sel_d;
			result_ch.active_function  <= cur_fn_d;
			result_ch.active_sub       <= sub_sel_d[cur_fn_d];
			result_ch.menu_state_index <= idx_d;
			result_ch.menu_state_valid <= idx_valid_d;
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_keypad_menu_navigator_top.sv -----
`timescale 1ns / 1ps

module tb_keypad_menu_navigator_top;
	import kmn_pkg::*;

	// Result beat as the block reports it, field for field.
	typedef struct packed {
		key_t             key;
		logic             sel;
		logic [FuncW-1:0] func;
		logic [SubW-1:0]  sub;
		logic [IdxW-1:0]  idx;
		logic             vld;
	} menu_result_t;

	// One row of the directed table; want is used only when typed is set.
	typedef struct packed {
		logic [AdcW-1:0] adc;
		logic            typed;
		menu_result_t    want;
	} press_row_t;

	localparam logic [CfgIdxW-1:0] SUB_COUNT_0 = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] SUB_COUNT_1 = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] SUB_COUNT_2 = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] SUB_COUNT_3 = CfgIdxW'(3);

	localparam int DirRows    = 25;
	localparam int HoldCycles = 80;
	localparam int MaxPrinted = 40;

	logic clk;
	logic arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CntW-1:0]     cfg_data;

	kmn_in_if  sample_if ();
	kmn_out_if result_if ();

	keypad_menu_navigator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_if),
		.result_ch (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Menu shadow: the state we expect the block to hold after each accepted beat.
	logic [FuncW-1:0] menu_func;
	logic [SubW-1:0]  menu_sub [NumSlots];
	logic             menu_lock;
	logic [IdxW-1:0]  menu_idx;
	logic             menu_idx_vld;
	logic [CntW-1:0]  menu_count [NumCfg];

	menu_result_t due_q[$];
	menu_result_t due;
	int errors     = 0;
	bit rx_idle_on = 1'b1;
	bit calm       = 1'b0;
	bit hold_req   = 1'b0;
	int hold_left  = 0;
	int stall_left = 0;

	// Directed presses. Typed rows start from reset with all counts at 12;
	// the last rows lean on the shadow model instead.
	press_row_t dir_tab [DirRows] = '{
		// idle reading at full scale, then just above the upper none threshold
		'{10'd1023, 1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd0,  6'd0,  1'b0}},
		'{10'd1001, 1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd0,  6'd0,  1'b0}},
		// all-zero reading is right; a second right sample is locked out
		'{10'd0,    1'b1, '{KEY_RIGHT,  1'b0, 2'd0, 4'd1,  6'd1,  1'b1}},
		'{10'd49,   1'b1, '{KEY_RIGHT,  1'b0, 2'd0, 4'd1,  6'd1,  1'b1}},
		// exactly 1000 falls through every compare to none
		'{10'd1000, 1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd1,  6'd1,  1'b1}},
		'{10'd50,   1'b1, '{KEY_UP,     1'b0, 2'd1, 4'd0,  6'd12, 1'b1}},
		'{10'd850,  1'b1, '{KEY_NONE,   1'b0, 2'd1, 4'd0,  6'd12, 1'b1}},
		'{10'd249,  1'b1, '{KEY_UP,     1'b0, 2'd2, 4'd0,  6'd24, 1'b1}},
		'{10'd999,  1'b1, '{KEY_NONE,   1'b0, 2'd2, 4'd0,  6'd24, 1'b1}},
		'{10'd250,  1'b1, '{KEY_DOWN,   1'b0, 2'd1, 4'd0,  6'd12, 1'b1}},
		'{10'd1002, 1'b1, '{KEY_NONE,   1'b0, 2'd1, 4'd0,  6'd12, 1'b1}},
		'{10'd449,  1'b1, '{KEY_DOWN,   1'b0, 2'd0, 4'd1,  6'd1,  1'b1}},
		'{10'd900,  1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd1,  6'd1,  1'b1}},
		'{10'd450,  1'b1, '{KEY_LEFT,   1'b0, 2'd0, 4'd0,  6'd0,  1'b1}},
		'{10'd1023, 1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd0,  6'd0,  1'b1}},
		// left from sub zero wraps to the top of the count
		'{10'd649,  1'b1, '{KEY_LEFT,   1'b0, 2'd0, 4'd11, 6'd11, 1'b1}},
		'{10'd950,  1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd11, 6'd11, 1'b1}},
		// select flags once, then is locked
		'{10'd650,  1'b1, '{KEY_SELECT, 1'b1, 2'd0, 4'd11, 6'd11, 1'b1}},
		'{10'd849,  1'b1, '{KEY_SELECT, 1'b0, 2'd0, 4'd11, 6'd11, 1'b1}},
		'{10'd1023, 1'b1, '{KEY_NONE,   1'b0, 2'd0, 4'd11, 6'd11, 1'b1}},
		// down from function zero wraps to the last function
		'{10'd250,  1'b0, '0},
		'{10'd1010, 1'b0, '0},
		// largest index: last function, last sub
		'{10'd649,  1'b0, '0},
		'{10'd1023, 1'b0, '0},
		// up from the last function wraps to zero
		'{10'd100,  1'b0, '0}
	};

	function automatic key_t decode_ladder(logic [AdcW-1:0] v);
		if (v > ThrNoneHi) return KEY_NONE;
		if (v < ThrRight)  return KEY_RIGHT;
		if (v < ThrUp)     return KEY_UP;
		if (v < ThrDown)   return KEY_DOWN;
		if (v < ThrLeft)   return KEY_LEFT;
		if (v < ThrSelect) return KEY_SELECT;
		return KEY_NONE;
	endfunction

	// Effective wrap count: zero acts as one, anything above the stride as the stride.
	function automatic int wrap_count(logic [FuncW-1:0] f);
		int c;
		c = menu_count[f];
		if (c < 1) c = 1;
		if (c > SUB_STRIDE_DEF) c = SUB_STRIDE_DEF;
		return c;
	endfunction

	// Advance the menu shadow by one sample and return the result beat it should cause.
	function automatic menu_result_t advance_menu(logic [AdcW-1:0] adc);
		menu_result_t r;
		key_t k;
		int s;
		int c;
		bit moved;
		k = decode_ladder(adc);
		r = '0;
		moved = 1'b0;
		if (k == KEY_NONE) begin
			menu_lock = 1'b0;
		end else if (!menu_lock) begin
			menu_lock = 1'b1;
			case (k)
				KEY_UP: begin
					menu_func = (int'(menu_func) + 1 >= NUM_FUNCTIONS_DEF) ? '0 : menu_func + 1'b1;
					moved = 1'b1;
				end
				KEY_DOWN: begin
					menu_func = (menu_func == 0) ? FuncW'(NUM_FUNCTIONS_DEF - 1) : menu_func - 1'b1;
					moved = 1'b1;
				end
				KEY_RIGHT: begin
					c = wrap_count(menu_func);
					s = int'(menu_sub[menu_func]) + 1;
					if (s >= c) s = 0;
					menu_sub[menu_func] = SubW'(s);
					moved = 1'b1;
				end
				KEY_LEFT: begin
					c = wrap_count(menu_func);
					s = menu_sub[menu_func];
					s = (s == 0) ? c - 1 : s - 1;
					menu_sub[menu_func] = SubW'(s);
					moved = 1'b1;
				end
				default: begin
					r.sel = 1'b1;
				end
			endcase
			if (moved) begin
				menu_idx = IdxW'(int'(menu_func) * SUB_STRIDE_DEF + int'(menu_sub[menu_func]));
				menu_idx_vld = 1'b1;
			end
		end
		r.key  = k;
		r.func = menu_func;
		r.sub  = menu_sub[menu_func];
		r.idx  = menu_idx;
		r.vld  = menu_idx_vld;
		return r;
	endfunction

	// Pick a ladder reading that decodes to the given key.
	function automatic logic [AdcW-1:0] ladder_voltage_for(key_t k);
		case (k)
			KEY_RIGHT:  return AdcW'($urandom_range(0, 49));
			KEY_UP:     return AdcW'($urandom_range(50, 249));
			KEY_DOWN:   return AdcW'($urandom_range(250, 449));
			KEY_LEFT:   return AdcW'($urandom_range(450, 649));
			KEY_SELECT: return AdcW'($urandom_range(650, 849));
			default:    return $urandom_range(0, 1) ? AdcW'($urandom_range(850, 1000))
				: AdcW'($urandom_range(1001, 1023));
		endcase
	endfunction

	task automatic report_miss(string what, int got, int want);
		if (errors < MaxPrinted)
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Offer one sample beat, hold it until accepted, then queue the result it should cause.
	task automatic press(logic [AdcW-1:0] adc, bit typed, menu_result_t want, bit gaps);
		menu_result_t pred;
		if (gaps && !calm && $urandom_range(0, 5) == 0) begin
			sample_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		sample_if.valid      <= 1'b1;
		sample_if.adc_sample <= adc;
		do @(posedge clk); while (!sample_if.ready);
		pred = advance_menu(adc);
		due_q.push_back(typed ? want : pred);
	endtask

	// Drop valid and wait until every queued result has been checked.
	task automatic settle();
		sample_if.valid <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Drive one register write and wait for the clock edge that takes it; the caller drops the enable afterwards.
	task automatic write_count(logic [CfgIdxW-1:0] idx, int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CntW'(val);
		@(posedge clk);
		menu_count[idx] = CntW'(val);
	endtask

	task automatic set_counts(int c0, int c1, int c2, int c3);
		write_count(SUB_COUNT_0, c0);
		write_count(SUB_COUNT_1, c1);
		write_count(SUB_COUNT_2, c2);
		write_count(SUB_COUNT_3, c3);
		cfg_we <= 1'b0;
	endtask

	// Mostly whole presses (key, a few held samples, release) with random content;
	// the rest is raw noise that can land on any key while locked.
	task automatic run_menu_phase(int n, bit gaps);
		int sent;
		key_t k;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 15) == 0) calm = !calm;
			if ($urandom_range(0, 9) < 8) begin
				k = key_t'($urandom_range(1, 5));
				press(ladder_voltage_for(k), 1'b0, '0, gaps);
				sent++;
				repeat ($urandom_range(0, 3)) begin
					press(ladder_voltage_for(k), 1'b0, '0, gaps);
					sent++;
				end
				repeat ($urandom_range(1, 2)) begin
					press(ladder_voltage_for(KEY_NONE), 1'b0, '0, gaps);
					sent++;
				end
			end else begin
				press(AdcW'($urandom_range(0, 1023)), 1'b0, '0, gaps);
				sent++;
			end
		end
	endtask

	// Result side: random stall bursts, plus one long hold-off on request so that
	// both pipeline registers fill and the sample channel backs up.
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HoldCycles;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_if.ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	// Check every accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (due_q.size() == 0) begin
				report_miss("result beat with nothing expected", 1, 0);
			end else begin
				due = due_q.pop_front();
				if (result_if.key_code !== due.key)
					report_miss("key_code", int'(result_if.key_code), int'(due.key));
				if (result_if.select_pressed !== due.sel)
					report_miss("select_pressed", int'(result_if.select_pressed), int'(due.sel));
				if (result_if.active_function !== due.func)
					report_miss("active_function", int'(result_if.active_function),
						int'(due.func));
				if (result_if.active_sub !== due.sub)
					report_miss("active_sub", int'(result_if.active_sub), int'(due.sub));
				if (result_if.menu_state_index !== due.idx)
					report_miss("menu_state_index", int'(result_if.menu_state_index),
						int'(due.idx));
				if (result_if.menu_state_valid !== due.vld)
					report_miss("menu_state_valid", int'(result_if.menu_state_valid),
						int'(due.vld));
			end
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#3ms;
		$display("keypad_menu_navigator_top regression: fail");
		$finish;
	end

	initial begin
		int i;
		// Drive every input to a known value before reset releases.
		arst_n               = 1'b0;
		sample_if.valid      = 1'b0;
		sample_if.adc_sample = '0;
		result_if.ready      = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		menu_func    = '0;
		menu_lock    = 1'b0;
		menu_idx     = '0;
		menu_idx_vld = 1'b0;
		for (i = 0; i < NumSlots; i++) menu_sub[i] = '0;
		for (i = 0; i < NumCfg; i++) menu_count[i] = CountReset;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed presses at reset counts.
		for (i = 0; i < DirRows; i++)
			press(dir_tab[i].adc, dir_tab[i].typed, dir_tab[i].want, 1'b1);
		settle();

		// Out-of-range counts; function 0 sits at sub 11, far above a count of one.
		// Hold the result side off for a long stretch while samples keep coming.
		set_counts(0, 1, 13, 15);
		hold_req = 1'b1;
		run_menu_phase(120, 1'b1);
		settle();

		// Back to the full stride everywhere.
		set_counts(12, 12, 12, 12);
		run_menu_phase(120, 1'b1);
		settle();

		// Two rounds of random counts over the whole register range.
		repeat (2) begin
			set_counts($urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 15));
			run_menu_phase(120, 1'b1);
			settle();
		end

		// Last stretch at full rate on both sides.
		set_counts(1, 15, 0, 12);
		rx_idle_on = 1'b0;
		run_menu_phase(150, 1'b0);
		settle();

		if (errors == 0)
			$display("keypad_menu_navigator_top regression: pass");
		else
			$display("keypad_menu_navigator_top regression: fail");
		$finish;
	end

endmodule

// ----- keypad_menu_navigator_top.f -----
rtl/kmn_pkg.sv
rtl/kmn_in_if.sv
rtl/kmn_out_if.sv
rtl/kmn_key_decode.sv
rtl/keypad_menu_navigator_top.sv
tb/tb_keypad_menu_navigator_top.sv
